### design/assert_macros.svh
// Assertion helpers for the design folder.
// Each check is clocked on clk_i and is off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Implication: when pre holds, post must hold in the same cycle.
`define ASSERT_IMPLY(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, prop)
`define ASSERT_IMPLY(label, pre, post)

`endif

`endif

### design/lbam_pkg.sv
`default_nettype none

package lbam_pkg;

  localparam int unsigned CAPACITY_DEF  = 1024;
  localparam int unsigned ADDR_BITS_DEF = 48;

  // Fixed field widths of the item formats.
  localparam int unsigned ADDR_W   = 48;
  localparam int unsigned COUNT_W  = 11;
  localparam int unsigned STATUS_W = 3;

  typedef enum logic {
    MODE_LOOKUP = 1'b0,
    MODE_UPSERT = 1'b1
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  typedef struct packed {
    logic              mode;
    logic [ADDR_W-1:0] logical_block;
    logic [ADDR_W-1:0] new_physical;
  } in_item_t;

  typedef struct packed {
    status_e            status;
    logic [ADDR_W-1:0]  physical_out;
    logic [COUNT_W-1:0] entry_count;
  } out_item_t;

endpackage

`default_nettype wire

### design/lba_map_upsert_lookup.sv
// Logical-to-physical block address map with lookup and upsert.
//
// Input channel (in_valid_i / in_ready_o / in_data_i) carries one request:
// mode selects lookup or upsert, logical_block is the key and new_physical
// the value to store on upsert. Output channel (out_valid_o / out_ready_i /
// out_data_o) returns one result per request: status, physical_out and the
// entry count after the request.
//
// Entries fill slots 0..count-1 in order and are never removed, so the fill
// count alone tells which slots hold data. A request scans the key memory one
// slot per cycle through a single comparator until it hits or reaches the
// last filled slot; each slot is read into a register and compared from it,
// and an empty map goes straight to S_FINISH. One request is in flight at a
// time; in_ready_o is high only when the sequencer is idle, so a new request
// is taken only after the last one has left S_FINISH.
//
// Reset clears the fill count and the output valid; memory contents are not
// cleared and need no sweep. A result held by a stalled receiver stays in the
// output register; the next request may still be accepted and scanned, and
// it waits at its final step until the output register frees up.
`default_nettype none
`include "assert_macros.svh"

module lba_map_upsert_lookup #(
  parameter int unsigned CAPACITY  = lbam_pkg::CAPACITY_DEF,
  parameter int unsigned ADDR_BITS = lbam_pkg::ADDR_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire lbam_pkg::in_item_t in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output lbam_pkg::out_item_t     out_data_o
);

  import lbam_pkg::*;

  // Stored key/value width: ADDR_BITS, capped by the item field width.
  localparam int unsigned KW = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CapFull = CW'(CAPACITY);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] cmp_idx_q, cmp_idx_d;
  logic          cmp_vld_q, cmp_vld_d;
  logic          mode_q, mode_d;
  logic [KW-1:0] key_q, key_d;
  logic [KW-1:0] val_q, val_d;
  logic          found_q, found_d;
  logic [IW-1:0] slot_q, slot_d;
  logic [KW-1:0] old_q, old_d;
  logic          out_valid_q, out_valid_d;
  out_item_t     out_q, out_d;

  logic [KW-1:0] key_mem [CAPACITY];
  logic [KW-1:0] val_mem [CAPACITY];
  logic [KW-1:0] key_rd_q, val_rd_q;

  logic          key_we, val_we;
  logic [IW-1:0] wr_addr;
  logic [IW-1:0] rd_addr;
  logic          hit, last, out_free;

  assign rd_addr  = idx_q[IW-1:0];
  assign hit      = cmp_vld_q && (key_rd_q == key_q);
  assign last     = cmp_vld_q && (cmp_idx_q == count_q - 1'b1);
  assign out_free = !out_valid_q || out_ready_i;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[wr_addr] <= key_q;
    end
    key_rd_q <= key_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[wr_addr] <= val_q;
    end
    val_rd_q <= val_mem[rd_addr];
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    cmp_idx_d   = idx_q;
    cmp_vld_d   = (state_q == S_SCAN);
    mode_d      = mode_q;
    key_d       = key_q;
    val_d       = val_q;
    found_d     = found_q;
    slot_d      = slot_q;
    old_d       = old_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    key_we      = 1'b0;
    val_we      = 1'b0;
    wr_addr     = slot_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          mode_d  = in_data_i.mode;
          key_d   = in_data_i.logical_block[KW-1:0];
          val_d   = in_data_i.new_physical[KW-1:0];
          found_d = 1'b0;
          idx_d   = '0;
          state_d = (count_q == '0) ? S_FINISH : S_SCAN;
        end
      end

      S_SCAN: begin
        // Keep reading ahead until the last filled slot has been issued.
        if (idx_q != count_q - 1'b1) begin
          idx_d = idx_q + 1'b1;
        end
        if (hit) begin
          found_d = 1'b1;
          slot_d  = cmp_idx_q[IW-1:0];
          old_d   = val_rd_q;
          state_d = S_FINISH;
        end else if (last) begin
          state_d = S_FINISH;
        end
      end

      S_FINISH: begin
        if (out_free) begin
          out_d.physical_out = '0;
          if (mode_q == MODE_LOOKUP) begin
            out_d.status = found_q ? ST_FOUND : ST_NOT_FOUND;
            if (found_q) begin
              out_d.physical_out = ADDR_W'(old_q);
            end
          end else if (found_q) begin
            out_d.status       = ST_UPDATED;
            out_d.physical_out = ADDR_W'(old_q);
            val_we             = 1'b1;
          end else if (count_q != CapFull) begin
            out_d.status = ST_INSERTED;
            wr_addr      = count_q[IW-1:0];
            key_we       = 1'b1;
            val_we       = 1'b1;
            count_d      = count_q + 1'b1;
          end else begin
            out_d.status = ST_FULL;
          end
          out_d.entry_count = COUNT_W'(count_d);
          out_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      cmp_idx_q   <= '0;
      cmp_vld_q   <= 1'b0;
      mode_q      <= 1'b0;
      key_q       <= '0;
      val_q       <= '0;
      found_q     <= 1'b0;
      slot_q      <= '0;
      old_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      cmp_idx_q   <= cmp_idx_d;
      cmp_vld_q   <= cmp_vld_d;
      mode_q      <= mode_d;
      key_q       <= key_d;
      val_q       <= val_d;
      found_q     <= found_d;
      slot_q      <= slot_d;
      old_q       <= old_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  `ASSERT_ALWAYS(a_count_bound, count_q <= CapFull)
  `ASSERT_IMPLY(a_count_moves_at_finish, !$stable(count_q), $past(state_q) == S_FINISH)
  `ASSERT_IMPLY(a_result_from_finish, $rose(out_valid_q), $past(state_q) == S_FINISH)
  `ASSERT_IMPLY(a_compare_in_range, state_q == S_SCAN && cmp_vld_q, cmp_idx_q < count_q)
  `ASSERT_IMPLY(a_scan_needs_entries, state_q == S_SCAN, count_q != '0)

endmodule

`default_nettype wire
